[hdl/utf8d_pkg.sv]
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types and constants shared by the UTF-8 decoder front end, queue and back end.
// ----------------------------------------------------------------------------
package utf8d_pkg;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 21;
   localparam int DATA_W = 7;

   localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
   localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
   localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;
   localparam logic [CP_W-1:0] LIM_ONE   = 21'h000080;
   localparam logic [CP_W-1:0] LIM_TWO   = 21'h000800;
   localparam logic [CP_W-1:0] LIM_THREE = 21'h010000;

   localparam logic [2:0] LEN_ONE   = 3'd1;
   localparam logic [2:0] LEN_TWO   = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR  = 3'd4;

   // Byte classes as seen by the front end.
   typedef enum logic [2:0] {
      CLS_ASCII,
      CLS_CONT,
      CLS_LEAD2,
      CLS_LEAD3,
      CLS_LEAD4,
      CLS_BAD
   } cls_type;

   // One classified byte on its way from the front end to the back end.
   typedef struct packed {
      cls_type             cls;
      logic [DATA_W-1:0]   data;   // payload bits, already masked for the class
      logic                eos;
   } item_type;

   // Queue status seen by its producer and consumer.
   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage

[hdl/utf8d_front.sv]
// ----------------------------------------------------------------------------
// utf8d_front
// Classifies each incoming byte and strips its marker bits before queuing it.
// ----------------------------------------------------------------------------
module utf8d_front
   import utf8d_pkg::*;
(
   input  logic [BYTE_W-1:0] in_byte,
   input  logic              end_of_string,
   output item_type          item
);

   always_comb begin
      item.eos  = end_of_string;
      item.data = '0;
      case (in_byte) inside
         [8'h00:8'h7F]: begin
            item.cls  = CLS_ASCII;
            item.data = in_byte[6:0];
         end
         [8'h80:8'hBF]: begin
            item.cls  = CLS_CONT;
            item.data = {1'b0, in_byte[5:0]};
         end
         [8'hC0:8'hDF]: begin
            item.cls  = CLS_LEAD2;
            item.data = {2'b00, in_byte[4:0]};
         end
         [8'hE0:8'hEF]: begin
            item.cls  = CLS_LEAD3;
            item.data = {3'b000, in_byte[3:0]};
         end
         [8'hF0:8'hF7]: begin
            item.cls  = CLS_LEAD4;
            item.data = {4'b0000, in_byte[2:0]};
         end
         default: begin
            item.cls  = CLS_BAD;
         end
      endcase
   end

endmodule

[hdl/utf8d_queue.sv]
// ----------------------------------------------------------------------------
// utf8d_queue
// Small register queue that decouples the classifier from the decoder.
// ----------------------------------------------------------------------------
module utf8d_queue
   import utf8d_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  item_type  push_item,
   input  logic      pop,
   output item_type  head_item,
   output qstat_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   item_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_FULL);
   assign head_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push)
      else $error("queue pushed while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !pop)
      else $error("queue popped while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count out of range");
`endif

endmodule

[hdl/utf8d_back.sv]
// ----------------------------------------------------------------------------
// utf8d_back
// Sequence decoder: gathers payload bits, validates, and holds the result register.
// ----------------------------------------------------------------------------
module utf8d_back
   import utf8d_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  item_type        head_item,
   input  qstat_type       q_status,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [CP_W-1:0] rsp_code_point,
   output logic            rsp_has_code_point,
   output logic            rsp_decode_error,
   output logic            rsp_string_done
);

   logic [CP_W-1:0] partial_ff, partial_in;
   logic [1:0]      remain_ff, remain_in;
   logic [2:0]      seqlen_ff, seqlen_in;
   logic            err_ff, err_in;

   logic            valid_ff, valid_in;
   logic [CP_W-1:0] cp_ff, cp_in;
   logic            has_ff, has_in;
   logic            derr_ff, derr_in;
   logic            done_ff, done_in;

   logic            emit, set_fail;
   logic [CP_W-1:0] emit_cp;
   logic            emit_has;
   logic [CP_W-1:0] joined;
   logic [1:0]      remain_dec;
   logic [2:0]      need_len;

   assign pop = !q_status.empty && (!valid_ff || rsp_ready);

   assign joined     = {partial_ff[CP_W-7:0], head_item.data[5:0]};
   assign remain_dec = remain_ff - 1'b1;

   always_comb begin
      if (joined < LIM_ONE) begin
         need_len = LEN_ONE;
      end else if (joined < LIM_TWO) begin
         need_len = LEN_TWO;
      end else if (joined < LIM_THREE) begin
         need_len = LEN_THREE;
      end else begin
         need_len = LEN_FOUR;
      end
   end

   always_comb begin
      partial_in = partial_ff;
      remain_in  = remain_ff;
      seqlen_in  = seqlen_ff;
      err_in     = err_ff;
      emit       = 1'b0;
      set_fail   = 1'b0;
      emit_cp    = '0;
      emit_has   = 1'b0;

      if (pop) begin
         if (err_ff) begin
            // Rest of a bad string is dropped; only its end reports.
            emit = head_item.eos;
         end else if (remain_ff == 2'd0) begin
            case (head_item.cls)
               CLS_ASCII: begin
                  emit     = 1'b1;
                  emit_has = 1'b1;
                  emit_cp  = CP_W'(head_item.data);
               end
               CLS_LEAD2: begin
                  seqlen_in  = LEN_TWO;
                  remain_in  = 2'd1;
                  partial_in = CP_W'(head_item.data);
                  set_fail   = head_item.eos;
               end
               CLS_LEAD3: begin
                  seqlen_in  = LEN_THREE;
                  remain_in  = 2'd2;
                  partial_in = CP_W'(head_item.data);
                  set_fail   = head_item.eos;
               end
               CLS_LEAD4: begin
                  seqlen_in  = LEN_FOUR;
                  remain_in  = 2'd3;
                  partial_in = CP_W'(head_item.data);
                  set_fail   = head_item.eos;
               end
               default: begin
                  set_fail = 1'b1;
               end
            endcase
         end else if (head_item.cls != CLS_CONT) begin
            // The offending byte is consumed, not taken as a new lead.
            set_fail = 1'b1;
         end else if (remain_dec != 2'd0) begin
            partial_in = joined;
            remain_in  = remain_dec;
            set_fail   = head_item.eos;
         end else begin
            partial_in = '0;
            remain_in  = 2'd0;
            seqlen_in  = '0;
            if (joined > CP_MAX || (joined >= SURR_LO && joined <= SURR_HI)
                || need_len != seqlen_ff) begin
               set_fail = 1'b1;
            end else begin
               emit     = 1'b1;
               emit_has = 1'b1;
               emit_cp  = joined;
            end
         end

         if (set_fail) begin
            emit       = 1'b1;
            emit_has   = 1'b0;
            emit_cp    = '0;
            err_in     = 1'b1;
            remain_in  = 2'd0;
            seqlen_in  = '0;
            partial_in = '0;
         end
         if (emit && head_item.eos) begin
            err_in     = 1'b0;
            remain_in  = 2'd0;
            seqlen_in  = '0;
            partial_in = '0;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      cp_in    = cp_ff;
      has_in   = has_ff;
      derr_in  = derr_ff;
      done_in  = done_ff;
      if (emit) begin
         valid_in = 1'b1;
         cp_in    = emit_cp;
         has_in   = emit_has;
         // An error result, or the end of a string that already failed.
         derr_in  = !emit_has;
         done_in  = head_item.eos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         remain_ff  <= '0;
         seqlen_ff  <= '0;
         err_ff     <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         partial_ff <= partial_in;
         remain_ff  <= remain_in;
         seqlen_ff  <= seqlen_in;
         err_ff     <= err_in;
         valid_ff   <= valid_in;
      end
      cp_ff   <= cp_in;
      has_ff  <= has_in;
      derr_ff <= derr_in;
      done_ff <= done_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_code_point     = cp_ff;
   assign rsp_has_code_point = has_ff;
   assign rsp_decode_error   = derr_ff;
   assign rsp_string_done    = done_ff;

`ifndef SYNTHESIS
   a_has_xor_err: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (has_ff != derr_ff))
      else $error("result carries both or neither of code point and error");
   a_err_no_seq: assert property (@(posedge clock) disable iff (reset)
      err_ff |-> (remain_ff == 2'd0 && seqlen_ff == 3'd0))
      else $error("sequence still open after an error");
   a_remain_fits: assert property (@(posedge clock) disable iff (reset)
      (remain_ff != 2'd0) |-> ({1'b0, remain_ff} < seqlen_ff))
      else $error("bytes still due exceed sequence length");
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (emit && head_item.eos) |=> (!err_ff && remain_ff == 2'd0))
      else $error("state not cleared after end of string");
`endif

endmodule

[hdl/utf8_to_codepoint_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder
// UTF-8 to Unicode scalar value decoder with validation, one byte per transfer.
//
//   Channel | Direction | Handshake            | Payload
//   req     | in        | req_valid/req_ready  | in_byte, end_of_string
//   rsp     | out       | rsp_valid/rsp_ready  | code_point, has_code_point,
//           |           |                      | decode_error, string_done
//
// While rsp is not stalled, sustained rate is one byte per cycle; the decoder
// back end handles one queued byte per cycle. A byte is queued, then its result
// registered. Reset is synchronous and clears the queue, the sequence state and
// rsp_valid. Bytes that produce no result still pass through the queue. A
// stalled rsp side fills the queue; req_ready drops only when it is full.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder
   import utf8d_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_in_byte,
   input  logic              req_end_of_string,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CP_W-1:0]   rsp_code_point,
   output logic              rsp_has_code_point,
   output logic              rsp_decode_error,
   output logic              rsp_string_done
);

   item_type  front_item;
   item_type  head_item;
   qstat_type q_status;
   logic      push;
   logic      pop;

   assign req_ready = !q_status.full;
   assign push      = req_valid && req_ready;

   utf8d_front u_front (
      .in_byte       (req_in_byte),
      .end_of_string (req_end_of_string),
      .item          (front_item)
   );

   utf8d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (q_status)
   );

   utf8d_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_item          (head_item),
      .q_status           (q_status),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_code_point     (rsp_code_point),
      .rsp_has_code_point (rsp_has_code_point),
      .rsp_decode_error   (rsp_decode_error),
      .rsp_string_done    (rsp_string_done)
   );

endmodule
